// ===== src/srle_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srle_pkg
// Shared widths, constants and types of the subpicture RLE line decoder.
// ----------------------------------------------------------------------------
package srle_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COLOR_W     = 2;
   localparam int unsigned LEN_W       = 13;
   localparam int unsigned WIDTH_W     = 13;
   // longest code is four nybbles with a 3-nybble prefix below 0x40
   localparam int unsigned CODE_W      = 10;
   localparam int unsigned PART_W      = 6;
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd720;

   localparam logic [CODE_W-1:0] DONE1_MIN = 10'h004;
   localparam logic [CODE_W-1:0] DONE2_MIN = 10'h010;
   localparam logic [CODE_W-1:0] DONE3_MIN = 10'h040;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [LEN_W-1:0]   length;
      logic               eol;
   } srle_run_type;

   // one decoded byte: one or two runs
   typedef struct packed {
      logic         two;
      srle_run_type first;
      srle_run_type second;
   } srle_entry_type;

   typedef struct packed {
      logic           valid;
      srle_entry_type entry;
   } srle_push_type;

endpackage
`default_nettype wire

// ===== src/srle_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srle_req_if / srle_rsp_if
// Valid/ready channels for coded bytes in and pixel runs out.
// ----------------------------------------------------------------------------
interface srle_req_if import srle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              data_exhausted;

   modport source (output valid, output data_byte, output data_exhausted, input ready);
   modport sink   (input valid, input data_byte, input data_exhausted, output ready);
endinterface

interface srle_rsp_if import srle_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] run_color;
   logic [LEN_W-1:0]   run_length;
   logic               end_of_line;
   logic               last;

   modport source (output valid, output run_color, output run_length,
                   output end_of_line, output last, input ready);
   modport sink   (input valid, input run_color, input run_length,
                   input end_of_line, input last, output ready);
endinterface
`default_nettype wire

// ===== src/srle_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srle_front
// Accepts coded bytes, assembles nybble codes, clips runs to the line and
// pushes the one or two runs of each byte into the run queue.
// ----------------------------------------------------------------------------
module srle_front import srle_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [WIDTH_W-1:0]  line_width,
   input  wire logic                full,
   output srle_push_type            push,
   srle_req_if.sink                 req_bus
);

   localparam int unsigned PW = $clog2(MAX_WIDTH + 1);

   typedef struct packed {
      logic               done;
      logic [PART_W-1:0]  part;
      logic [1:0]         pend;
      logic [COLOR_W-1:0] color;
      logic [PW-1:0]      len;
      logic [PW-1:0]      pos;
      logic               eol;
   } step_type;

   function automatic step_type nyb_step(input logic [PART_W-1:0] part,
                                         input logic [1:0]        pend,
                                         input logic [3:0]        nyb,
                                         input logic [PW-1:0]     pos,
                                         input logic [PW-1:0]     w);
      step_type              s;
      logic [CODE_W-1:0]     code;
      logic [CODE_W-3:0]     count;
      logic [PW-1:0]         rem;
      logic [PW-1:0]         sum;
      code   = {part, nyb};
      count  = code[CODE_W-1:2];
      s.done = (pend == 2'd3) ||
               (pend == 2'd0 && code >= DONE1_MIN) ||
               (pend == 2'd1 && code >= DONE2_MIN) ||
               (pend == 2'd2 && code >= DONE3_MIN);
      s.part  = s.done ? '0 : code[PART_W-1:0];
      s.pend  = s.done ? 2'd0 : pend + 2'd1;
      s.color = code[COLOR_W-1:0];
      rem = w - pos;
      // zero count runs to end of line
      if (count == '0 || LEN_W'(count) > LEN_W'(rem)) begin
         s.len = rem;
      end else begin
         s.len = PW'(count);
      end
      sum   = pos + s.len;
      s.eol = (sum == w);
      // an unfinished code leaves the position alone
      if (!s.done) begin
         s.pos = pos;
      end else begin
         s.pos = s.eol ? '0 : sum;
      end
      return s;
   endfunction

   logic [PART_W-1:0] part_ff, part_in;
   logic [1:0]        pend_ff, pend_in;
   logic [PW-1:0]     pos_ff, pos_in;

   logic [PW-1:0]     width_use;
   logic [PW-1:0]     pos_start;
   step_type          step_a;
   step_type          step_b;
   logic              go_b;
   logic              done_b;
   logic              accept;
   srle_run_type      run_a;
   srle_run_type      run_b;

   always_comb begin
      if (line_width == '0) begin
         width_use = PW'(1);
      end else if (line_width > WIDTH_W'(MAX_WIDTH)) begin
         width_use = PW'(MAX_WIDTH);
      end else begin
         width_use = PW'(line_width);
      end
   end

   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && req_bus.ready;

   // a width shrink can leave the position past the line end
   assign pos_start = (pos_ff >= width_use) ? '0 : pos_ff;

   always_comb begin
      step_a = nyb_step(part_ff, pend_ff, req_bus.data_byte[7:4], pos_start, width_use);
      step_b = nyb_step(step_a.part, step_a.pend, req_bus.data_byte[3:0],
                        step_a.pos, width_use);
   end

   // line end in the high nybble drops the low nybble
   assign go_b   = !(step_a.done && step_a.eol);
   assign done_b = go_b && step_b.done;

   assign run_a = '{color: step_a.color, length: LEN_W'(step_a.len), eol: step_a.eol};
   assign run_b = '{color: step_b.color, length: LEN_W'(step_b.len), eol: step_b.eol};

   always_comb begin
      push.valid        = 1'b0;
      push.entry.two    = 1'b0;
      push.entry.first  = run_a;
      push.entry.second = run_b;
      part_in           = part_ff;
      pend_in           = pend_ff;
      pos_in            = pos_ff;
      if (accept) begin
         if (req_bus.data_exhausted) begin
            push.valid              = 1'b1;
            push.entry.first.color  = '0;
            push.entry.first.length = LEN_W'(width_use - pos_start);
            push.entry.first.eol    = 1'b1;
            part_in                 = '0;
            pend_in                 = 2'd0;
            pos_in                  = '0;
         end else begin
            push.valid       = step_a.done || done_b;
            push.entry.two   = step_a.done && done_b;
            push.entry.first = step_a.done ? run_a : run_b;
            if (go_b) begin
               part_in = step_b.part;
               pend_in = step_b.pend;
               pos_in  = step_b.pos;
            end else begin
               part_in = step_a.part;
               pend_in = step_a.pend;
               pos_in  = step_a.pos;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff <= '0;
         pend_ff <= 2'd0;
         pos_ff  <= '0;
      end else begin
         part_ff <= part_in;
         pend_ff <= pend_in;
         pos_ff  <= pos_in;
      end
   end

   a_no_partial_when_empty : assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd0 |-> part_ff == '0)
      else $error("partial code bits held with no pending nybbles");

   a_exhaust_restarts_line : assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.data_exhausted |=> pos_ff == '0 && pend_ff == 2'd0)
      else $error("data exhaustion did not restart the line");

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into a full run queue");

endmodule
`default_nettype wire

// ===== src/srle_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srle_back
// Run queue and output serializer: holds decoded bytes and sends their runs
// one beat at a time, marking the last run of each byte.
// ----------------------------------------------------------------------------
module srle_back import srle_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  srle_push_type  push,
   output logic           full,
   srle_rsp_if.source     rsp_bus
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   srle_entry_type   queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             sel_ff, sel_in;

   srle_entry_type   head;
   srle_run_type     cur;
   logic             beat;
   logic             pop;

   assign head = queue_ff[rd_ptr_ff];
   assign cur  = sel_ff ? head.second : head.first;

   assign rsp_bus.valid       = (count_ff != '0);
   assign rsp_bus.run_color   = cur.color;
   assign rsp_bus.run_length  = cur.length;
   assign rsp_bus.end_of_line = cur.eol;
   assign rsp_bus.last        = sel_ff || !head.two;

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign beat = rsp_bus.valid && rsp_bus.ready;
   assign pop  = beat && rsp_bus.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      sel_in    = sel_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         sel_in    = 1'b0;
      end else if (beat) begin
         sel_in = 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         queue_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sel_ff    <= sel_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("run queue count beyond depth");

   a_second_run_valid : assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> count_ff != '0 && head.two)
      else $error("second run selected on a single-run entry");

   a_push_counts : assert property (@(posedge clock) disable iff (reset)
      push.valid && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push not reflected in queue count");

endmodule
`default_nettype wire

// ===== src/subpicture_rle_line_decoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// subpicture_rle_line_decoder_core
// Decodes 2-bit subpicture run-length line data into clipped pixel runs.
// ----------------------------------------------------------------------------
// Usage:
//  req_bus carries one coded byte per beat (high nybble first) or, with
//  data_exhausted set, a request to fill the rest of the line with color 0.
//  rsp_bus carries pixel runs: color, clipped length, end_of_line, and last
//  on the final run of each byte. A byte that completes no code gives none.
//  csr_write_en/csr_write_data set the line width; write only while idle.
// Timing:
//  Runs are queued as their byte is accepted. The front end takes a byte
//  every cycle while the queue is not full; the output serializer sends
//  one run per cycle while rsp_bus.ready is high, so a byte with two runs
//  holds the output for both. A four-entry queue between the two absorbs
//  that and receiver stalls; req_bus.ready drops only when it is full.
// Reset:
//  Synchronous, active high. Clears code assembly, line position and queue;
//  line width returns to 720.
// ----------------------------------------------------------------------------
module subpicture_rle_line_decoder_core import srle_pkg::*; #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_en,
   input  wire logic [WIDTH_W-1:0] csr_write_data,
   srle_req_if.sink                req_bus,
   srle_rsp_if.source              rsp_bus
);

   logic [WIDTH_W-1:0] line_width_ff, line_width_in;
   srle_push_type      push;
   logic               full;

   assign line_width_in = csr_write_en ? csr_write_data : line_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= WIDTH_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   srle_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .full       (full),
      .push       (push),
      .req_bus    (req_bus)
   );

   srle_back u_back (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (full),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire
